[sv/ctb_pkg.sv]
package ctb_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_LEFT  = 2'd1;
    localparam logic [1:0] OP_RIGHT = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    // Command after classification: exactly one kind bit is set.
    typedef struct packed {
        logic       is_add;
        logic       is_left;
        logic       is_right;
        logic       is_flush;
        logic [7:0] ch;
    } cmd_t;

endpackage

[sv/ctb_front.sv]
module ctb_front
    import ctb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    input  logic [7:0] char_in,
    output logic       busy,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    cmd_t       decoded;
    logic       push;
    logic       pop;

    always_comb
    begin
        decoded          = '0;
        decoded.ch       = char_in;
        case (operation)
            OP_ADD:   decoded.is_add   = 1'b1;
            OP_LEFT:  decoded.is_left  = 1'b1;
            OP_RIGHT: decoded.is_right = 1'b1;
            OP_FLUSH: decoded.is_flush = 1'b1;
            default:  decoded.is_flush = 1'b1;
        endcase
    end

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop)
        else $error("pop from empty queue");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> $onehot({cmd.is_add, cmd.is_left, cmd.is_right, cmd.is_flush}))
        else $error("queued command not classified");
`endif

endmodule

[sv/ctb_back.sv]
module ctb_back
    import ctb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    output logic       strobe,
    output logic [7:0] char_out,
    output logic       last,
    output logic       empty_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOVE  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] lc_reg;
    logic [CNT_W-1:0] lc_next;
    logic [CNT_W-1:0] rc_reg;
    logic [CNT_W-1:0] rc_next;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic             dir_reg;
    logic             dir_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic             pend_src_reg;
    logic             pend_src_next;
    logic             pend_last_reg;
    logic             pend_last_next;
    logic             pend_empty_reg;
    logic             pend_empty_next;

    logic [7:0]        l_mem [CAPACITY];
    logic [7:0]        r_mem [CAPACITY];
    logic [7:0]        l_rdata_reg;
    logic [7:0]        r_rdata_reg;
    logic              l_we;
    logic              l_re;
    logic [ADDR_W-1:0] l_waddr;
    logic [ADDR_W-1:0] l_raddr;
    logic [7:0]        l_wdata;
    logic              r_we;
    logic              r_re;
    logic [ADDR_W-1:0] r_waddr;
    logic [ADDR_W-1:0] r_raddr;
    logic [7:0]        r_wdata;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] lc_dec;
    logic [CNT_W-1:0] rc_dec;
    logic [CNT_W-1:0] r_flush_idx;
    logic             flush_end;

    assign total       = lc_reg + rc_reg;
    assign lc_dec      = lc_reg - CNT_W'(1);
    assign rc_dec      = rc_reg - CNT_W'(1);
    // The right stack is read top first, so its index counts down from rc_reg - 1 to 0.
    assign r_flush_idx = total - k_reg - CNT_W'(1);
    assign flush_end   = (k_reg == total - CNT_W'(1));
    assign cmd_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        lc_next         = lc_reg;
        rc_next         = rc_reg;
        k_next          = k_reg;
        dir_next        = dir_reg;
        pend_valid_next = 1'b0;
        pend_src_next   = pend_src_reg;
        pend_last_next  = pend_last_reg;
        pend_empty_next = pend_empty_reg;
        l_we            = 1'b0;
        l_re            = 1'b0;
        l_waddr         = lc_reg[ADDR_W-1:0];
        l_raddr         = lc_dec[ADDR_W-1:0];
        l_wdata         = cmd.ch;
        r_we            = 1'b0;
        r_re            = 1'b0;
        r_waddr         = rc_reg[ADDR_W-1:0];
        r_raddr         = rc_dec[ADDR_W-1:0];
        r_wdata         = l_rdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_add)
                    begin
                        if (total < CNT_W'(CAPACITY))
                        begin
                            l_we    = 1'b1;
                            lc_next = lc_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd.is_left)
                    begin
                        if (lc_reg != '0)
                        begin
                            l_re       = 1'b1;
                            lc_next    = lc_dec;
                            dir_next   = 1'b0;
                            state_next = ST_MOVE;
                        end
                    end
                    else if (cmd.is_right)
                    begin
                        if (rc_reg != '0)
                        begin
                            r_re       = 1'b1;
                            rc_next    = rc_dec;
                            dir_next   = 1'b1;
                            state_next = ST_MOVE;
                        end
                    end
                    else if (total == '0)
                    begin
                        pend_valid_next = 1'b1;
                        pend_last_next  = 1'b1;
                        pend_empty_next = 1'b1;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_MOVE:
            begin
                // The character read last cycle lands on top of the other stack.
                if (dir_reg)
                begin
                    l_we    = 1'b1;
                    l_wdata = r_rdata_reg;
                    lc_next = lc_reg + CNT_W'(1);
                end
                else
                begin
                    r_we    = 1'b1;
                    rc_next = rc_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                pend_valid_next = 1'b1;
                pend_empty_next = 1'b0;
                pend_last_next  = flush_end;
                if (k_reg < lc_reg)
                begin
                    l_re          = 1'b1;
                    l_raddr       = k_reg[ADDR_W-1:0];
                    pend_src_next = 1'b0;
                end
                else
                begin
                    r_re          = 1'b1;
                    r_raddr       = r_flush_idx[ADDR_W-1:0];
                    pend_src_next = 1'b1;
                end
                k_next = k_reg + CNT_W'(1);
                if (flush_end)
                begin
                    lc_next    = '0;
                    rc_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lc_reg         <= '0;
            rc_reg         <= '0;
            k_reg          <= '0;
            dir_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_src_reg   <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lc_reg         <= lc_next;
            rc_reg         <= rc_next;
            k_reg          <= k_next;
            dir_reg        <= dir_next;
            pend_valid_reg <= pend_valid_next;
            pend_src_reg   <= pend_src_next;
            pend_last_reg  <= pend_last_next;
            pend_empty_reg <= pend_empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            l_mem[l_waddr] <= l_wdata;
        end
        if (l_re)
        begin
            l_rdata_reg <= l_mem[l_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            r_mem[r_waddr] <= r_wdata;
        end
        if (r_re)
        begin
            r_rdata_reg <= r_mem[r_raddr];
        end
    end

    assign strobe    = pend_valid_reg;
    assign last      = pend_last_reg;
    assign empty_res = pend_empty_reg;
    assign char_out  = pend_empty_reg ? 8'd0 : (pend_src_reg ? r_rdata_reg : l_rdata_reg);

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, lc_reg} + {1'b0, rc_reg} <= (CNT_W + 1)'(CAPACITY))
        else $error("stack counts exceed capacity");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH && flush_end |=> lc_reg == '0 && rc_reg == '0)
        else $error("buffer not cleared after flush");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && empty_res |-> last && char_out == 8'd0)
        else $error("empty flush beat malformed");

    a_move_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |=> state_reg == ST_IDLE)
        else $error("cursor move did not complete");
`endif

endmodule

[sv/cursor_text_buffer_top.sv]
// An accepted command is registered in the queue before it reaches the execution
// stage. Insert is one stack write there; a cursor move is a stack read, then a write.
// Flush of N characters gives N beats (a single empty beat if none); each beat
// appears on the result ports in the cycle after its stack read, one beat per cycle.
// A two-entry command queue raises busy when full; results cannot be stalled.
// Reset clears the counts and queue; the stack memories keep undefined contents.
module cursor_text_buffer_top
    import ctb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_in,
    output logic       strobe,
    output logic [7:0] char_out,
    output logic       last,
    output logic       empty_res
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    ctb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .char_in   (char_in),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    ctb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .strobe    (strobe),
        .char_out  (char_out),
        .last      (last),
        .empty_res (empty_res)
    );

endmodule
